/* hw/rtl/sqg_pkg.sv */
// Shared constants, register map and types of the single-qubit gate core.
`default_nettype none
package sqg_pkg;

  localparam int MAX_QUBITS  = 12;
  localparam int IDX_W       = MAX_QUBITS;
  localparam int ADDR_W      = MAX_QUBITS - 1;
  localparam int STORE_DEPTH = 1 << ADDR_W;
  localparam int AMP_W       = 16;
  localparam int COEF_W      = 16;
  localparam int WORD_W      = 2 * AMP_W;
  localparam int QCNT_FLD_W  = 4;
  localparam int CFG_DATA_W  = 32;
  localparam int CFG_IDX_W   = 3;

  // Decoupling queue between front and back.
  localparam int QDEPTH = 4;
  localparam int QPTR_W = 2;
  localparam int QCNT_W = 3;

  // Register map.
  localparam logic [CFG_IDX_W-1:0] REG_QUBIT_COUNT  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_QUBIT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GATE_U00     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GATE_U01     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_GATE_U10     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_GATE_U11     = 3'd5;

  // Reset values: full register, target 1, Hadamard gate.
  localparam logic [QCNT_FLD_W-1:0] RST_QUBIT_COUNT  = 4'd12;
  localparam logic [QCNT_FLD_W-1:0] RST_TARGET_QUBIT = 4'd1;
  localparam logic [CFG_DATA_W-1:0] RST_GATE_U00     = 32'h2D41_0000;
  localparam logic [CFG_DATA_W-1:0] RST_GATE_U01     = 32'h2D41_0000;
  localparam logic [CFG_DATA_W-1:0] RST_GATE_U10     = 32'h2D41_0000;
  localparam logic [CFG_DATA_W-1:0] RST_GATE_U11     = 32'hD2BF_0000;

  typedef struct packed {
    logic [CFG_DATA_W-1:0] u00;
    logic [CFG_DATA_W-1:0] u01;
    logic [CFG_DATA_W-1:0] u10;
    logic [CFG_DATA_W-1:0] u11;
  } gate_t;

  // One amplitude pair ready for the gate.
  typedef struct packed {
    logic [WORD_W-1:0] a0;      // bit-clear amplitude, re high / im low
    logic [WORD_W-1:0] a1;      // bit-set amplitude
    logic [IDX_W-1:0]  idx_lo;  // index with target bit clear
    logic [IDX_W-1:0]  idx_hi;  // index with target bit set
    logic              last;    // idx_hi is the final index of the vector
  } q_entry_t;

endpackage
`default_nettype wire

/* hw/rtl/single_qubit_gate_state_update_core.sv */
// Path: a partner word reads its partner from the pairing store; the pair is registered,
//   queued, and its two results, bit-clear first, go through the product stage and output
//   register. A bit-clear word produces nothing on its own. Throughput: up to one word per
//   cycle in and out as the handshakes allow; a full 4-entry queue stalls bit-set words.
// Reset (synchronous, rst_n low): index, queue and pipeline control cleared, registers to
//   12 qubits, target 1, Hadamard gate; the pairing store is not cleared.
`default_nettype none
module single_qubit_gate_state_update_core import sqg_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // configuration
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  // amplitude word in, index order
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [AMP_W-1:0]      in_amp_re,
  input  wire logic [AMP_W-1:0]      in_amp_im,
  // updated amplitude word out
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [IDX_W-1:0]           out_index,
  output logic [AMP_W-1:0]           out_re,
  output logic [AMP_W-1:0]           out_im,
  output logic                       out_last_out
);

  logic [QCNT_FLD_W-1:0] qubit_count_r;
  logic [QCNT_FLD_W-1:0] target_qubit_r;
  gate_t                 gate_r;
  logic                  restart;
  logic                  q_push, q_pop, q_valid;
  q_entry_t              q_in, q_head;
  logic [QCNT_W-1:0]     q_count;

  // Writing the qubit count or the target restarts the stream at index 0.
  assign restart = cfg_we &&
                   ((cfg_index == REG_QUBIT_COUNT) || (cfg_index == REG_TARGET_QUBIT));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      qubit_count_r  <= RST_QUBIT_COUNT;
      target_qubit_r <= RST_TARGET_QUBIT;
      gate_r.u00     <= RST_GATE_U00;
      gate_r.u01     <= RST_GATE_U01;
      gate_r.u10     <= RST_GATE_U10;
      gate_r.u11     <= RST_GATE_U11;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_QUBIT_COUNT:  qubit_count_r  <= cfg_wdata[QCNT_FLD_W-1:0];
        REG_TARGET_QUBIT: target_qubit_r <= cfg_wdata[QCNT_FLD_W-1:0];
        REG_GATE_U00:     gate_r.u00     <= cfg_wdata;
        REG_GATE_U01:     gate_r.u01     <= cfg_wdata;
        REG_GATE_U10:     gate_r.u10     <= cfg_wdata;
        REG_GATE_U11:     gate_r.u11     <= cfg_wdata;
        default: ;  // unmapped index: ignored
      endcase
    end
  end

  // Front: tracks the index, parks bit-clear words, pairs bit-set words.
  sqg_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .restart      (restart),
    .qubit_count  (qubit_count_r),
    .target_qubit (target_qubit_r),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_amp_re    (in_amp_re),
    .in_amp_im    (in_amp_im),
    .q_count      (q_count),
    .q_push       (q_push),
    .q_entry      (q_in)
  );

  // Queue decouples pairing from the arithmetic.
  sqg_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (q_in),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head       (q_head),
    .count      (q_count)
  );

  // Back: two results per pair, bit-clear index first.
  sqg_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .gate         (gate_r),
    .q_valid      (q_valid),
    .q_head       (q_head),
    .q_pop        (q_pop),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_index    (out_index),
    .out_re       (out_re),
    .out_im       (out_im),
    .out_last_out (out_last_out)
  );

endmodule
`default_nettype wire

/* hw/rtl/sqg_ram.sv */
// Generic single-port-write, registered-read RAM.
`default_nettype none
module sqg_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 2048
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/sqg_front.sv */
// Front end: index tracking, pairing store and queue push.
`default_nettype none
module sqg_front import sqg_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  restart,
  input  wire logic [QCNT_FLD_W-1:0] qubit_count,
  input  wire logic [QCNT_FLD_W-1:0] target_qubit,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [AMP_W-1:0]      in_amp_re,
  input  wire logic [AMP_W-1:0]      in_amp_im,
  input  wire logic [QCNT_W-1:0]     q_count,
  output logic                       q_push,
  output q_entry_t                   q_entry
);

  logic [IDX_W-1:0]      next_index_r, next_index_nxt;
  logic [QCNT_FLD_W-1:0] n_lim;
  logic [QCNT_FLD_W-1:0] t_pos;
  logic [IDX_W-1:0]      size_mask, idx, bitm, low_mask;
  logic [ADDR_W-1:0]     addr;
  logic                  tgt_ok, is_set, is_partner, room, accept, st_we, st_re;
  logic [QCNT_W:0]       used;
  logic [WORD_W-1:0]     cur, rd_word;
  logic                  rd_v_r;
  logic [WORD_W-1:0]     cur_r;
  logic [IDX_W-1:0]      lo_r, hi_r;
  logic                  last_r;

  always_comb begin
    n_lim      = (qubit_count > QCNT_FLD_W'(MAX_QUBITS)) ? QCNT_FLD_W'(MAX_QUBITS)
                                                         : qubit_count;
    size_mask  = ~({IDX_W{1'b1}} << n_lim);
    idx        = next_index_r & size_mask;
    tgt_ok     = (target_qubit != '0) && (target_qubit <= n_lim);
    t_pos      = n_lim - target_qubit;
    bitm       = IDX_W'(1) << t_pos;
    low_mask   = bitm - IDX_W'(1);
    is_set     = |(idx & bitm);
    // store address: index with the target bit squeezed out
    addr       = ADDR_W'(((idx >> 1) & ~low_mask) | (idx & low_mask));
    is_partner = tgt_ok && is_set;
    used       = {1'b0, q_count} + (QCNT_W+1)'(rd_v_r);
    room       = used < (QCNT_W+1)'(QDEPTH);
    // only a partner word needs queue space
    in_ready   = !is_partner || room;
    accept     = in_valid && in_ready;
    st_we      = accept && tgt_ok && !is_set;
    st_re      = accept && is_partner;
    cur        = {in_amp_re, in_amp_im};
    next_index_nxt = (idx + IDX_W'(1)) & size_mask;
  end

  sqg_ram #(
    .WIDTH (WORD_W),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (st_we),
    .waddr (addr),
    .wdata (cur),
    .re    (st_re),
    .raddr (addr),
    .rdata (rd_word)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      next_index_r <= '0;
      rd_v_r       <= 1'b0;
    end else begin
      if (restart) begin
        next_index_r <= '0;
      end else if (accept) begin
        next_index_r <= next_index_nxt;
      end
      rd_v_r <= st_re;
    end
  end

  always_ff @(posedge clk) begin
    if (st_re) begin
      cur_r  <= cur;
      hi_r   <= idx;
      lo_r   <= idx ^ bitm;
      last_r <= (idx == size_mask);
    end
  end

  always_comb begin
    q_push         = rd_v_r;
    q_entry.a0     = rd_word;
    q_entry.a1     = cur_r;
    q_entry.idx_lo = lo_r;
    q_entry.idx_hi = hi_r;
    q_entry.last   = last_r;
  end

endmodule
`default_nettype wire

/* hw/rtl/sqg_queue.sv */
// Short FIFO of amplitude pairs between front and back.
`default_nettype none
module sqg_queue import sqg_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  q_entry_t               push_entry,
  input  wire logic              pop,
  output logic                   head_valid,
  output q_entry_t               head,
  output logic [QCNT_W-1:0]      count
);

  q_entry_t          mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] count_r;
  logic              do_pop;

  assign do_pop     = pop && (count_r != '0);
  assign head_valid = (count_r != '0);
  assign head       = mem_r[rd_ptr_r];
  assign count      = count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      end
      count_r <= count_r + QCNT_W'(push) - QCNT_W'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/sqg_back.sv */
// Back end: complex multiply-accumulate, rounding and output register.
`default_nettype none
module sqg_back import sqg_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  gate_t                  gate,
  input  wire logic              q_valid,
  input  q_entry_t               q_head,
  output logic                   q_pop,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [IDX_W-1:0]       out_index,
  output logic [AMP_W-1:0]       out_re,
  output logic [AMP_W-1:0]       out_im,
  output logic                   out_last_out
);

  localparam int PROD_W = AMP_W + COEF_W;
  localparam int ACC_W  = PROD_W + 3;

  function automatic logic [AMP_W-1:0] round_sat(input logic signed [ACC_W-1:0] acc);
    logic signed [ACC_W-1:0] sh;
    sh = (acc + ACC_W'(signed'(8192))) >>> 14;
    if (sh > ACC_W'(signed'(32767))) begin
      round_sat = 16'h7FFF;
    end else if (sh < -ACC_W'(signed'(32768))) begin
      round_sat = 16'h8000;
    end else begin
      round_sat = sh[AMP_W-1:0];
    end
  endfunction

  logic                      sel_r;
  logic                      s1_v_r, s1_en, s2_en, load;
  logic [CFG_DATA_W-1:0]     cp, cr;
  logic signed [COEF_W-1:0]  pr, pi, rr, ri;
  logic signed [AMP_W-1:0]   xr, xi, yr, yi;
  logic signed [PROD_W-1:0]  m_nxt [8];
  logic signed [PROD_W-1:0]  m_r   [8];
  logic [IDX_W-1:0]          s1_idx_r;
  logic                      s1_last_r;
  logic signed [ACC_W-1:0]   acc_re, acc_im;
  logic                      out_valid_r;
  logic [IDX_W-1:0]          out_index_r;
  logic [AMP_W-1:0]          out_re_r, out_im_r;
  logic                      out_last_r;

  always_comb begin
    s2_en = !out_valid_r || out_ready;
    s1_en = !s1_v_r || s2_en;
    load  = s1_en && q_valid;
    q_pop = load && sel_r;
    cp    = sel_r ? gate.u10 : gate.u00;
    cr    = sel_r ? gate.u11 : gate.u01;
    pr    = signed'(cp[31:16]);
    pi    = signed'(cp[15:0]);
    rr    = signed'(cr[31:16]);
    ri    = signed'(cr[15:0]);
    xr    = signed'(q_head.a0[31:16]);
    xi    = signed'(q_head.a0[15:0]);
    yr    = signed'(q_head.a1[31:16]);
    yi    = signed'(q_head.a1[15:0]);
    m_nxt[0] = pr * xr;
    m_nxt[1] = pi * xi;
    m_nxt[2] = rr * yr;
    m_nxt[3] = ri * yi;
    m_nxt[4] = pr * xi;
    m_nxt[5] = pi * xr;
    m_nxt[6] = rr * yi;
    m_nxt[7] = ri * yr;
    acc_re = ACC_W'(m_r[0]) - ACC_W'(m_r[1]) + ACC_W'(m_r[2]) - ACC_W'(m_r[3]);
    acc_im = ACC_W'(m_r[4]) + ACC_W'(m_r[5]) + ACC_W'(m_r[6]) + ACC_W'(m_r[7]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sel_r       <= 1'b0;
      s1_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (s1_en) begin
        s1_v_r <= q_valid;
      end
      if (load) begin
        sel_r <= !sel_r;
      end
      if (s2_en) begin
        out_valid_r <= s1_v_r;
      end
    end
  end

  // product stage
  always_ff @(posedge clk) begin
    if (load) begin
      for (int i = 0; i < 8; i++) begin
        m_r[i] <= m_nxt[i];
      end
      s1_idx_r  <= sel_r ? q_head.idx_hi : q_head.idx_lo;
      s1_last_r <= sel_r && q_head.last;
    end
  end

  // sum, round, saturate into the output register
  always_ff @(posedge clk) begin
    if (s2_en && s1_v_r) begin
      out_index_r <= s1_idx_r;
      out_re_r    <= round_sat(acc_re);
      out_im_r    <= round_sat(acc_im);
      out_last_r  <= s1_last_r;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_index    = out_index_r;
  assign out_re       = out_re_r;
  assign out_im       = out_im_r;
  assign out_last_out = out_last_r;

endmodule
`default_nettype wire

/* tb/single_qubit_gate_state_update_core_tb.sv */
// Self-checking testbench for the single-qubit gate state update core.
`timescale 1ns / 100ps
module single_qubit_gate_state_update_core_tb;
  import sqg_pkg::*;

  localparam int CLK_PERIOD     = 10;
  localparam int RESET_CYCLES   = 11;
  localparam int MAX_GAP        = 17;
  localparam int RESET_WORDS    = 200;
  localparam int PAIRED_WORDS   = 512;
  localparam int RANDOM_WORDS   = 950;
  // Receiver stalls for this long at two points in the run so the
  // 4-entry queue fills and in_ready drops while words keep coming.
  localparam int HOLD_CYCLES    = 400;
  localparam int HOLD_AT_FIRST  = 300;
  localparam int HOLD_AT_SECOND = 800;
  // Leave margin for the pipeline to empty when a setting produced
  // no results at all.
  localparam int SETTLE_CYCLES  = 12;
  localparam int CYCLE_LIMIT    = 1_000_000;
  localparam int MAX_REPORTS    = 40;

  // Indexes past the register map; writes there must change nothing.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

  typedef struct {
    logic [IDX_W-1:0] idx;
    logic [AMP_W-1:0] re;
    logic [AMP_W-1:0] im;
    logic             last;
  } amp_update_t;

  // Predicts updated amplitudes from the accepted word stream and
  // compares them, in order, against what the core delivers.
  class amp_pair_scoreboard;
    logic [QCNT_FLD_W-1:0] qcount;
    logic [QCNT_FLD_W-1:0] target;
    logic [CFG_DATA_W-1:0] u00, u01, u10, u11;
    logic [IDX_W-1:0]      next_idx;
    logic [WORD_W-1:0]     partner_store [STORE_DEPTH];
    amp_update_t           pending_updates [$];
    int                    errors;
    int                    words_seen;
    int                    updates_checked;

    function new();
      qcount          = RST_QUBIT_COUNT;
      target          = RST_TARGET_QUBIT;
      u00             = RST_GATE_U00;
      u01             = RST_GATE_U01;
      u10             = RST_GATE_U10;
      u11             = RST_GATE_U11;
      next_idx        = '0;
      errors          = 0;
      words_seen      = 0;
      updates_checked = 0;
    endfunction

    function int qubits_in_use();
      return (qcount > MAX_QUBITS) ? MAX_QUBITS : int'(qcount);
    endfunction

    function bit target_live();
      return target != 0 && int'(target) <= qubits_in_use();
    endfunction

    function void configure(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] value);
      case (index)
        REG_QUBIT_COUNT: begin
          qcount   = value[QCNT_FLD_W-1:0];
          next_idx = '0;
        end
        REG_TARGET_QUBIT: begin
          target   = value[QCNT_FLD_W-1:0];
          next_idx = '0;
        end
        REG_GATE_U00: u00 = value;
        REG_GATE_U01: u01 = value;
        REG_GATE_U10: u10 = value;
        REG_GATE_U11: u11 = value;
        default: ;
      endcase
    endfunction

    // Sum of Q3.29 products to Q1.15: round half up, then clamp.
    function logic [AMP_W-1:0] to_q15(longint acc);
      longint q;
      q = (acc + 64'sd8192) >>> 14;
      if (q > 32767)  q = 32767;
      if (q < -32768) q = -32768;
      return q[AMP_W-1:0];
    endfunction

    // p*a0 + r*a1, complex, words packed re high / im low.
    function void gate_row(logic [CFG_DATA_W-1:0] p, logic [CFG_DATA_W-1:0] r,
                           logic [WORD_W-1:0] a0, logic [WORD_W-1:0] a1,
                           output logic [AMP_W-1:0] o_re, output logic [AMP_W-1:0] o_im);
      longint pr, pi, rr, ri, xr, xi, yr, yi;
      pr = $signed(p[31:16]);
      pi = $signed(p[15:0]);
      rr = $signed(r[31:16]);
      ri = $signed(r[15:0]);
      xr = $signed(a0[31:16]);
      xi = $signed(a0[15:0]);
      yr = $signed(a1[31:16]);
      yi = $signed(a1[15:0]);
      o_re = to_q15(pr * xr - pi * xi + rr * yr - ri * yi);
      o_im = to_q15(pr * xi + pi * xr + rr * yi + ri * yr);
    endfunction

    function void note_amplitude(logic [AMP_W-1:0] re, logic [AMP_W-1:0] im);
      int                n;
      int                mask;
      int                idx;
      int                t;
      int                pair_bit;
      int                addr;
      logic [WORD_W-1:0] a0;
      amp_update_t       lo_upd;
      amp_update_t       hi_upd;
      words_seen++;
      n        = qubits_in_use();
      mask     = (1 << n) - 1;
      idx      = int'(next_idx) & mask;
      next_idx = IDX_W'((idx + 1) & mask);
      if (!target_live()) return;
      t        = n - int'(target);
      pair_bit = 1 << t;
      addr     = (((idx >> (t + 1)) << t) | (idx & (pair_bit - 1))) & (STORE_DEPTH - 1);
      if ((idx & pair_bit) == 0) begin
        partner_store[addr] = {re, im};
        return;
      end
      a0 = partner_store[addr];
      lo_upd.idx  = IDX_W'(idx ^ pair_bit);
      lo_upd.last = 1'b0;
      gate_row(u00, u01, a0, {re, im}, lo_upd.re, lo_upd.im);
      hi_upd.idx  = IDX_W'(idx);
      hi_upd.last = (idx == mask);
      gate_row(u10, u11, a0, {re, im}, hi_upd.re, hi_upd.im);
      pending_updates.push_back(lo_upd);
      pending_updates.push_back(hi_upd);
    endfunction

    task report_mismatch(string what);
      errors++;
      if (errors <= MAX_REPORTS) $display("[%0t] mismatch: %s", $time, what);
    endtask

    task check_update(amp_update_t got);
      amp_update_t want;
      if (pending_updates.size() == 0) begin
        report_mismatch($sformatf("word at index %0d with none pending", got.idx));
        return;
      end
      want = pending_updates.pop_front();
      updates_checked++;
      if (got.idx !== want.idx)
        report_mismatch($sformatf("index %0d, want %0d", got.idx, want.idx));
      if (got.re !== want.re)
        report_mismatch($sformatf("re %h at index %0d, want %h", got.re, want.idx, want.re));
      if (got.im !== want.im)
        report_mismatch($sformatf("im %h at index %0d, want %h", got.im, want.idx, want.im));
      if (got.last !== want.last)
        report_mismatch($sformatf("last %b at index %0d, want %b", got.last, want.idx,
                                  want.last));
    endtask
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [AMP_W-1:0]      in_amp_re = '0;
  logic [AMP_W-1:0]      in_amp_im = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [IDX_W-1:0]      out_index;
  logic [AMP_W-1:0]      out_re;
  logic [AMP_W-1:0]      out_im;
  logic                  out_last_out;

  amp_pair_scoreboard    sb = new();
  int                    cycle_count = 0;
  bit                    sender_burst = 1'b0;

  single_qubit_gate_state_update_core u_top (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_amp_re    (in_amp_re),
    .in_amp_im    (in_amp_im),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_index    (out_index),
    .out_re       (out_re),
    .out_im       (out_im),
    .out_last_out (out_last_out)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Hard stop in case the core wedges.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Amplitude with a heavy share of the rails, zero and -1 LSB.
  function automatic logic [AMP_W-1:0] rand_amp();
    case ($urandom_range(0, 9))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h0000;
      3: return 16'hFFFF;
      default: return AMP_W'($urandom);
    endcase
  endfunction

  // Coefficient near the Q2.14 extremes often enough to drive saturation.
  function automatic logic [CFG_DATA_W-1:0] rand_coef();
    case ($urandom_range(0, 7))
      0: return 32'h7FFF_7FFF;
      1: return 32'h8000_8000;
      2: return 32'h4000_0000;
      3: return 32'h8000_7FFF;
      default: return $urandom;
    endcase
  endfunction

  // Register write; the caller lowers cfg_we once the batch is done so
  // back-to-back writes never get two assignments in one step.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] index,
                           input logic [CFG_DATA_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= index;
    cfg_wdata <= value;
    @(posedge clk);
    sb.configure(index, value);
  endtask

  task automatic close_cfg();
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Offer one word; returns at the edge that took it. With no gap drawn,
  // valid simply stays high and only the payload changes.
  task automatic send_word(input logic [AMP_W-1:0] re, input logic [AMP_W-1:0] im);
    int gap;
    gap = sender_burst ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_amp_re <= re;
    in_amp_im <= im;
    do @(posedge clk); while (!in_ready);
    sb.note_amplitude(re, im);
  endtask

  // Stop sending and let every pending update come back, plus the
  // pipeline depth, so the next register write sees an idle core.
  task automatic settle();
    in_valid <= 1'b0;
    while (sb.pending_updates.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Receiver: random stalls per word, stall-free stretches now and then,
  // and two long hold-offs to back the core up into its input.
  initial begin : receiver
    int          gap;
    int          received;
    bit          rx_burst;
    amp_update_t got;
    received = 0;
    rx_burst = 1'b0;
    wait (rst_n);
    @(posedge clk);
    forever begin
      gap = rx_burst ? 0 : $urandom_range(0, MAX_GAP);
      if (received == HOLD_AT_FIRST || received == HOLD_AT_SECOND) gap = HOLD_CYCLES;
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      got.idx  = out_index;
      got.re   = out_re;
      got.im   = out_im;
      got.last = out_last_out;
      sb.check_update(got);
      received++;
      if (received % 64 == 0) rx_burst = ($urandom_range(0, 2) == 0);
    end
  end

  initial begin : stimulus
    int                    len;
    int                    n_eff;
    int                    random_words;
    int                    settings;
    logic [QCNT_FLD_W-1:0] qc;
    logic [QCNT_FLD_W-1:0] tq;
    random_words = 0;
    settings     = 1;

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // Reset setting untouched: 12 qubits, target 1, Hadamard. The paired
    // bit is the top one, so the opening words only fill the store.
    for (int i = 0; i < RESET_WORDS; i++) send_word(rand_amp(), rand_amp());
    settle();

    // Target 12 with the reset gate: every other word completes a pair.
    // The sender runs flat out, so the first receiver hold-off backs the
    // core up into its input.
    write_reg(REG_TARGET_QUBIT, 32'd12);
    close_cfg();
    settings++;
    sender_burst = 1'b1;
    for (int i = 0; i < PAIRED_WORDS; i++) send_word(rand_amp(), rand_amp());
    sender_burst = 1'b0;
    settle();

    // Directed: 1 qubit, coefficients at the rails so both sides clip.
    write_reg(REG_QUBIT_COUNT, 32'd1);
    write_reg(REG_TARGET_QUBIT, 32'd1);
    write_reg(REG_GATE_U00, 32'h7FFF_7FFF);
    write_reg(REG_GATE_U01, 32'h7FFF_7FFF);
    write_reg(REG_GATE_U10, 32'h8000_8000);
    write_reg(REG_GATE_U11, 32'h7FFF_8000);
    close_cfg();
    settings++;
    send_word(16'h7FFF, 16'h7FFF);
    send_word(16'h7FFF, 16'h7FFF);
    send_word(16'h8000, 16'h8000);
    send_word(16'h8000, 16'h8000);
    send_word(16'h0000, 16'h0000);
    send_word(16'hFFFF, 16'hFFFF);
    send_word(16'h8000, 16'h7FFF);
    send_word(16'h7FFF, 16'h8000);
    settle();

    // Directed: rounding at exactly half an LSB, both signs; u00 is one
    // Q2.14 LSB, u10 is 1.0, u11 is i.
    write_reg(REG_QUBIT_COUNT, 32'd2);
    write_reg(REG_TARGET_QUBIT, 32'd2);
    write_reg(REG_GATE_U00, 32'h0001_0000);
    write_reg(REG_GATE_U01, 32'h0000_0000);
    write_reg(REG_GATE_U10, 32'h4000_0000);
    write_reg(REG_GATE_U11, 32'h0000_4000);
    close_cfg();
    settings++;
    send_word(16'h2000, 16'hE000);
    send_word(16'h0001, 16'h7FFF);
    send_word(16'h6000, 16'h9FFF);
    send_word(16'hFFFF, 16'h0001);
    settle();

    // Directed: target above the qubit count, then target zero, then a
    // zero qubit count; none of these may produce a word.
    write_reg(REG_TARGET_QUBIT, 32'd3);
    close_cfg();
    settings++;
    repeat (3) send_word(rand_amp(), rand_amp());
    settle();
    write_reg(REG_TARGET_QUBIT, 32'd0);
    close_cfg();
    settings++;
    repeat (2) send_word(rand_amp(), rand_amp());
    settle();
    write_reg(REG_QUBIT_COUNT, 32'd0);
    write_reg(REG_TARGET_QUBIT, 32'd1);
    close_cfg();
    settings++;
    repeat (2) send_word(rand_amp(), rand_amp());
    settle();

    // Directed: qubit count beyond the maximum acts as the maximum; writes
    // to the unmapped indexes must not disturb anything.
    write_reg(REG_QUBIT_COUNT, 32'd15);
    write_reg(REG_TARGET_QUBIT, 32'd12);
    write_reg(REG_SPARE_LO, $urandom);
    write_reg(REG_SPARE_HI, $urandom);
    close_cfg();
    settings++;
    repeat (4) send_word(rand_amp(), rand_amp());
    settle();

    // Random phases. Most pick a fresh size and target (restarting the
    // stream); the rest only swap coefficients and carry on mid-vector.
    while (random_words < RANDOM_WORDS) begin
      if ($urandom_range(0, 9) < 7) begin
        case ($urandom_range(0, 9))
          0: qc = 4'd0;
          1: qc = QCNT_FLD_W'($urandom_range(13, 15));
          2: qc = QCNT_FLD_W'($urandom_range(7, 12));
          default: qc = QCNT_FLD_W'($urandom_range(1, 6));
        endcase
        n_eff = (qc > MAX_QUBITS) ? MAX_QUBITS : int'(qc);
        if (n_eff > 0 && $urandom_range(0, 6) != 0)
          tq = QCNT_FLD_W'($urandom_range(1, n_eff));
        else
          tq = QCNT_FLD_W'($urandom_range(0, 15));
        // Upper data bits are don't-care for the 4-bit fields.
        write_reg(REG_QUBIT_COUNT, {28'($urandom), qc});
        write_reg(REG_TARGET_QUBIT, {28'($urandom), tq});
      end
      if ($urandom_range(0, 2) == 0) write_reg(REG_GATE_U00, rand_coef());
      if ($urandom_range(0, 2) == 0) write_reg(REG_GATE_U01, rand_coef());
      if ($urandom_range(0, 2) == 0) write_reg(REG_GATE_U10, rand_coef());
      if ($urandom_range(0, 2) == 0) write_reg(REG_GATE_U11, rand_coef());
      if ($urandom_range(0, 7) == 0)
        write_reg($urandom_range(0, 1) ? REG_SPARE_HI : REG_SPARE_LO, $urandom);
      close_cfg();
      settings++;
      sender_burst = ($urandom_range(0, 3) == 0);

      // Small vectors run up to three times over; large ones take 16 to 300 words.
      n_eff = sb.qubits_in_use();
      if (!sb.target_live())
        len = $urandom_range(2, 12);
      else if (n_eff <= 6)
        len = $urandom_range(1, 3 << n_eff);
      else
        len = $urandom_range(16, 300);
      for (int i = 0; i < len; i++) begin
        send_word(rand_amp(), rand_amp());
        if (sb.target_live()) random_words++;
      end
      settle();
    end

    $display("Streamed %0d amplitude words over %0d register settings: reset Hadamard,",
             sb.words_seen, settings);
    $display("clipping, half-LSB rounding, dead targets, stalls; %0d words compared.",
             sb.updates_checked);
    if (sb.errors == 0 && sb.pending_updates.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

/* filelist.f */
hw/rtl/sqg_pkg.sv
hw/rtl/sqg_ram.sv
hw/rtl/sqg_front.sv
hw/rtl/sqg_queue.sv
hw/rtl/sqg_back.sv
hw/rtl/single_qubit_gate_state_update_core.sv
tb/single_qubit_gate_state_update_core_tb.sv
